// ----- rtl/core/variance_triggered_zero_suppress_top_assert.svh -----
// Assertion helpers used by the datapath of the zero suppression block.
`ifndef VARIANCE_TRIGGERED_ZERO_SUPPRESS_TOP_ASSERT_SVH
`define VARIANCE_TRIGGERED_ZERO_SUPPRESS_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define VTZS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vtzs assertion failed");

// Next-cycle implication, disabled while reset is held.
`define VTZS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vtzs assertion failed");

`endif

// ----- rtl/core/vtzs_pkg.sv -----
package vtzs_pkg;

  // Default sizing of the block
  localparam int DEF_HISTORY_DEPTH = 64;
  localparam int DEF_SAMPLE_BITS   = 12;
  localparam int DEF_INDEX_BITS    = 16;

  // Fixed field widths
  localparam int CH_W       = 16;
  localparam int THR_W      = 40;
  localparam int WLEN_W     = 7;
  localparam int PRE_W      = 6;
  localparam int POST_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_SAMPLES   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_SAMPLES  = 2'd3;

  // Register reset values
  localparam logic [WLEN_W-1:0] RST_WINDOW_LEN    = 7'd16;
  localparam logic [THR_W-1:0]  RST_VAR_THRESHOLD = 40'd4096;
  localparam logic [PRE_W-1:0]  RST_PRE_SAMPLES   = 6'd4;
  localparam logic [POST_W-1:0] RST_POST_SAMPLES  = 10'd16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // take the input beat
    logic sum_start;  // clear accumulators and history offset
    logic sum_rd;     // read one window sample and step the offset up
    logic mul;        // form L*Q and S*S
    logic cmp;        // evaluate the trigger and apply it
    logic rep_rd;     // read one pre-trigger sample
    logic pass_load;  // load a post-trigger sample into the output register
    logic rep_load;   // load a replayed sample into the output register
  } vtzs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic post_pend;  // record window still open
    logic eval_ok;    // index has reached the window length
    logic sum_last;   // current read is the oldest window sample
    logic trig;       // variance trigger fires
    logic has_emit;   // trigger produces at least one replayed beat
    logic out_free;   // output register can take a beat this cycle
    logic rep_last;   // current replayed beat is the last from history
  } vtzs_stat_t;

endpackage

// ----- rtl/core/vtzs_ifs.sv -----
// Sample input channel
interface vtzs_in_if import vtzs_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [CH_W-1:0]        channel;
  logic                   first_of_waveform;
  logic                   last_of_waveform;

  modport source (output valid, sample, channel, first_of_waveform, last_of_waveform,
                  input ready);
  modport sink   (input valid, sample, channel, first_of_waveform, last_of_waveform,
                  output ready);
endinterface

// Recorded sample output channel
interface vtzs_out_if import vtzs_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int INDEX_BITS  = DEF_INDEX_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] kept_sample;
  logic [INDEX_BITS-1:0]  kept_index;
  logic [INDEX_BITS-1:0]  window_start;
  logic [CH_W-1:0]        out_channel;
  logic                   last_of_window;

  modport source (output valid, kept_sample, kept_index, window_start, out_channel,
                  last_of_window, input ready);
  modport sink   (input valid, kept_sample, kept_index, window_start, out_channel,
                  last_of_window, output ready);
endinterface

// Register write channel
interface vtzs_cfg_if import vtzs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/vtzs_ctrl.sv -----
module vtzs_ctrl import vtzs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  vtzs_stat_t stat,
  output vtzs_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_PASS   = 4'd2;
  localparam logic [3:0] S_SUM    = 4'd3;
  localparam logic [3:0] S_DRAIN  = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_CMP    = 4'd6;
  localparam logic [3:0] S_REP_RD = 4'd7;
  localparam logic [3:0] S_REP_LD = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // Take a new beat only between items
  assign in_ready = (state_r == S_IDLE);

  // Sequence one item: route, sum the window, test, replay history
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.post_pend) begin
          state_nxt = S_PASS;
        end else if (stat.eval_ok) begin
          cmd.sum_start = 1'b1;
          state_nxt     = S_SUM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PASS: begin
        if (stat.out_free) begin
          cmd.pass_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SUM: begin
        cmd.sum_rd = 1'b1;
        if (stat.sum_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_MUL;
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (stat.trig && stat.has_emit) state_nxt = S_REP_RD;
        else                            state_nxt = S_IDLE;
      end
      S_REP_RD: begin
        cmd.rep_rd = 1'b1;
        state_nxt  = S_REP_LD;
      end
      S_REP_LD: begin
        if (stat.out_free) begin
          cmd.rep_load = 1'b1;
          state_nxt    = stat.rep_last ? S_IDLE : S_REP_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- rtl/core/vtzs_dp.sv -----
`include "variance_triggered_zero_suppress_top_assert.svh"

module vtzs_dp import vtzs_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
  parameter int INDEX_BITS    = DEF_INDEX_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vtzs_cmd_t              cmd,
  output vtzs_stat_t             stat,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [CH_W-1:0]        in_channel,
  input  logic                   in_first,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_kept_sample,
  output logic [INDEX_BITS-1:0]  out_kept_index,
  output logic [INDEX_BITS-1:0]  out_window_start,
  output logic [CH_W-1:0]        out_channel,
  output logic                   out_last_of_window
);

  localparam int PTR_W  = $clog2(HISTORY_DEPTH);
  localparam int AW     = PTR_W + 2;
  localparam int LW     = $clog2(HISTORY_DEPTH + 1);
  localparam int BACK_W = (PTR_W > PRE_W) ? PTR_W : PRE_W;
  localparam int SUM_W  = SAMPLE_BITS + PTR_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int QW     = 2 * SAMPLE_BITS + PTR_W;
  localparam int LHS_W  = LW + QW;
  localparam int RHS_W  = 2 * SUM_W;
  localparam int LR_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int CMP_W  = (LR_W > THR_W) ? LR_W : THR_W;
  localparam int REC_W  = ((INDEX_BITS > POST_W) ? INDEX_BITS : POST_W) + 1;

  // Registers
  logic [WLEN_W-1:0]      wlen_r;
  logic [THR_W-1:0]       thr_r;
  logic [PRE_W-1:0]       pre_r;
  logic [POST_W-1:0]      post_r;

  // Waveform state
  logic [PTR_W-1:0]       ptr_r;
  logic [INDEX_BITS-1:0]  cnt_r;
  logic [REC_W-1:0]       rec_end_r;
  logic [POST_W-1:0]      post_rem_r;
  logic [INDEX_BITS-1:0]  cws_r;
  logic [SUM_W-1:0]       sum_r;
  logic [QW-1:0]          sq_sum_r;

  // Current item
  logic [SAMPLE_BITS-1:0] s_r;
  logic [CH_W-1:0]        ch_r;
  logic                   last_r;
  logic [INDEX_BITS-1:0]  idx_r;
  logic [PTR_W-1:0]       cur_r;

  // Work registers
  logic [BACK_W-1:0]      back_r;
  logic                   acc_v_r;
  logic [SAMPLE_BITS-1:0] mem_q_r;
  logic [LHS_W-1:0]       lhs_r;
  logic [RHS_W-1:0]       rhs_r;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] kept_sample_r;
  logic [INDEX_BITS-1:0]  kept_index_r;
  logic [INDEX_BITS-1:0]  window_start_r;
  logic [CH_W-1:0]        channel_r;
  logic                   last_win_r;

  logic [SAMPLE_BITS-1:0] ring [HISTORY_DEPTH];

  logic [LW-1:0]          l_eff;
  logic [PRE_W-1:0]       pre_eff;
  logic [INDEX_BITS-1:0]  idx_in;
  logic [PTR_W-1:0]       ptr_inc;
  logic [AW-1:0]          addr_t;
  logic [PTR_W-1:0]       rd_addr;
  logic [SQ_W-1:0]        sq;
  logic [CMP_W:0]         diff;
  logic                   trig;
  logic [PRE_W-1:0]       n_pre;
  logic [INDEX_BITS-1:0]  start;
  logic                   post_zero;
  logic                   closes;
  logic                   pass_fin;
  logic                   rep_last;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= RST_WINDOW_LEN;
      thr_r  <= RST_VAR_THRESHOLD;
      pre_r  <= RST_PRE_SAMPLES;
      post_r <= RST_POST_SAMPLES;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW_LEN:    wlen_r <= cfg_data[WLEN_W-1:0];
        CFG_VAR_THRESHOLD: thr_r  <= cfg_data[THR_W-1:0];
        CFG_PRE_SAMPLES:   pre_r  <= cfg_data[PRE_W-1:0];
        CFG_POST_SAMPLES:  post_r <= cfg_data[POST_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp window length to 1..depth and pre count to depth-1
  always_comb begin
    if (wlen_r == '0)                         l_eff = LW'(1);
    else if (32'(wlen_r) > HISTORY_DEPTH)     l_eff = LW'(HISTORY_DEPTH);
    else                                      l_eff = LW'(wlen_r);
    if (32'(pre_r) > HISTORY_DEPTH - 1)       pre_eff = PRE_W'(HISTORY_DEPTH - 1);
    else                                      pre_eff = pre_r;
  end

  assign idx_in  = in_first ? '0 : cnt_r;
  assign ptr_inc = (32'(ptr_r) == HISTORY_DEPTH - 1) ? '0 : ptr_r + 1'b1;

  // History address: current slot minus offset, modulo depth
  always_comb begin
    addr_t = AW'(cur_r) + AW'(HISTORY_DEPTH) - AW'(back_r);
    if (addr_t >= AW'(HISTORY_DEPTH)) addr_t = addr_t - AW'(HISTORY_DEPTH);
    rd_addr = addr_t[PTR_W-1:0];
  end

  // History ring: write on accept, registered read
  always_ff @(posedge clk) begin
    if (cmd.accept) ring[ptr_r] <= in_sample;
    if (cmd.sum_rd || cmd.rep_rd) mem_q_r <= ring[rd_addr];
  end

  // Latch the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_r    <= in_sample;
      ch_r   <= in_channel;
      last_r <= in_last;
      idx_r  <= idx_in;
      cur_r  <= ptr_r;
    end
  end

  // Accumulate sum and sum of squares one sample per cycle
  assign sq = SQ_W'(mem_q_r) * SQ_W'(mem_q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_v_r  <= 1'b0;
      sum_r    <= '0;
      sq_sum_r <= '0;
    end else begin
      acc_v_r <= cmd.sum_rd;
      if ((cmd.accept && in_first) || cmd.sum_start) begin
        sum_r    <= '0;
        sq_sum_r <= '0;
      end else if (acc_v_r) begin
        sum_r    <= sum_r + SUM_W'(mem_q_r);
        sq_sum_r <= sq_sum_r + QW'(sq);
      end
    end
  end

  // Form both products for the variance test
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      lhs_r <= LHS_W'(l_eff) * LHS_W'(sq_sum_r);
      rhs_r <= RHS_W'(sum_r) * RHS_W'(sum_r);
    end
  end

  // Trigger test and record window bounds
  always_comb begin
    diff = (CMP_W + 1)'(lhs_r) - (CMP_W + 1)'(rhs_r);
    trig = !diff[CMP_W] && (diff[CMP_W-1:0] > CMP_W'(thr_r)) &&
           (REC_W'(idx_r) > rec_end_r);
    if (32'(idx_r) >= 32'(pre_eff)) n_pre = pre_eff;
    else                            n_pre = PRE_W'(idx_r);
    start     = idx_r - INDEX_BITS'(n_pre);
    post_zero = (post_r == '0);
    closes    = (post_r <= POST_W'(1)) || last_r;
    pass_fin  = (post_rem_r == POST_W'(1)) || last_r;
    rep_last  = (back_r == BACK_W'(post_zero));
  end

  // History offset: up while summing, down while replaying
  always_ff @(posedge clk) begin
    if (cmd.sum_start)     back_r <= '0;
    else if (cmd.sum_rd)   back_r <= back_r + 1'b1;
    else if (cmd.cmp)      back_r <= BACK_W'(n_pre);
    else if (cmd.rep_load) back_r <= back_r - 1'b1;
  end

  // Waveform position, record end and open window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      cnt_r      <= '0;
      rec_end_r  <= '0;
      post_rem_r <= '0;
      cws_r      <= '0;
    end else if (cmd.accept) begin
      ptr_r <= ptr_inc;
      cnt_r <= idx_in + 1'b1;
      if (in_first) begin
        rec_end_r  <= '0;
        post_rem_r <= '0;
        cws_r      <= '0;
      end
    end else if (cmd.pass_load) begin
      post_rem_r <= pass_fin ? '0 : post_rem_r - 1'b1;
    end else if (cmd.cmp && trig) begin
      cws_r      <= start;
      rec_end_r  <= REC_W'(idx_r) + REC_W'(post_r);
      post_rem_r <= closes ? '0 : post_r - 1'b1;
    end
  end

  // Output register: hold a beat until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n)                            out_valid_r <= 1'b0;
    else if (cmd.pass_load || cmd.rep_load) out_valid_r <= 1'b1;
    else if (out_ready)                    out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_load) begin
      kept_sample_r  <= s_r;
      kept_index_r   <= idx_r;
      window_start_r <= cws_r;
      channel_r      <= ch_r;
      last_win_r     <= pass_fin;
    end else if (cmd.rep_load) begin
      kept_sample_r  <= mem_q_r;
      kept_index_r   <= idx_r - INDEX_BITS'(back_r);
      window_start_r <= cws_r;
      channel_r      <= ch_r;
      last_win_r     <= rep_last && closes;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kept_sample    = kept_sample_r;
  assign out_kept_index     = kept_index_r;
  assign out_window_start   = window_start_r;
  assign out_channel        = channel_r;
  assign out_last_of_window = last_win_r;

  always_comb begin
    stat           = '0;
    stat.post_pend = (post_rem_r != '0);
    stat.eval_ok   = (32'(idx_r) >= 32'(l_eff));
    stat.sum_last  = (32'(back_r) == 32'(l_eff) - 1);
    stat.trig      = trig;
    stat.has_emit  = (n_pre != '0) || !post_zero;
    stat.out_free  = !out_valid_r || out_ready;
    stat.rep_last  = rep_last;
  end

  `VTZS_ASSERT_IMPL(a_load_when_free, clk, rst_n, cmd.pass_load || cmd.rep_load, !out_valid_r || out_ready)
  `VTZS_ASSERT_IMPL(a_read_in_range, clk, rst_n, cmd.sum_rd || cmd.rep_rd, 32'(back_r) < HISTORY_DEPTH)
  `VTZS_ASSERT_IMPL(a_no_sum_in_flight, clk, rst_n, cmd.accept, !acc_v_r)
  `VTZS_ASSERT_IMPL(a_pass_has_credit, clk, rst_n, cmd.pass_load, post_rem_r != '0)
  `VTZS_ASSERT_NEXT(a_trig_closes_eval, clk, rst_n, cmd.cmp && trig && !closes, post_rem_r != '0)

endmodule

// ----- rtl/core/variance_triggered_zero_suppress_top.sv -----
// Variance-triggered zero suppression with pre- and post-trigger samples.
// in_chan carries one ADC sample per beat with its channel number and the
// first/last-of-waveform marks; out_chan carries recorded samples with their
// waveform index, record window start and a last-of-window mark; cfg_chan
// writes window length, threshold, pre and post counts (always ready).
// An item with an open record window passes its sample straight to the output
// register. An item before the window length is reached is only stored in the
// history. An item that is tested walks the history memory one entry per cycle
// through its single read port to form the window sum, then forms the products
// and then makes the threshold compare. A trigger then replays up to
// pre_samples + 1 samples from history, each read and then loaded once the
// output register is free.
// The output register holds one beat, so a new item is taken while a result
// waits; when the receiver stalls, the next result stalls the block and
// in_chan.ready stays low until it moves.
// Reset loads the register defaults and clears all waveform state; the
// history memory is not cleared and needs no clearing pass.
module variance_triggered_zero_suppress_top import vtzs_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
  parameter int INDEX_BITS    = DEF_INDEX_BITS
) (
  input logic        clk,
  input logic        rst_n,
  vtzs_in_if.sink    in_chan,
  vtzs_out_if.source out_chan,
  vtzs_cfg_if.sink   cfg_chan
);

  vtzs_cmd_t  cmd;
  vtzs_stat_t stat;
  logic       in_ready;

  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;

  vtzs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vtzs_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .INDEX_BITS    (INDEX_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_valid          (cfg_chan.valid),
    .cfg_index          (cfg_chan.index),
    .cfg_data           (cfg_chan.data),
    .in_sample          (in_chan.sample),
    .in_channel         (in_chan.channel),
    .in_first           (in_chan.first_of_waveform),
    .in_last            (in_chan.last_of_waveform),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_kept_sample    (out_chan.kept_sample),
    .out_kept_index     (out_chan.kept_index),
    .out_window_start   (out_chan.window_start),
    .out_channel        (out_chan.out_channel),
    .out_last_of_window (out_chan.last_of_window)
  );

endmodule
